@@ hw/rtl/skt_pkg.sv @@
// Shared types, constants and helpers for the stereo keypoint triangulator.
// Used by the top level, skt_front and skt_back; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam int unsigned SKT_COORD_W     = 16;
  localparam int unsigned SKT_BASE_W      = 20;
  localparam int unsigned SKT_CFG_W       = 20;
  localparam int unsigned SKT_CFG_IDX_W   = 3;
  localparam int unsigned SKT_OUT_W       = 32;
  localparam int unsigned SKT_QUOT_W      = 32;
  localparam int unsigned SKT_QUEUE_DEPTH = 2;

  // Divider operand widths: dividend is 2*num + den, divisor is 2*den.
  localparam int unsigned SKT_NZ_W = 38;
  localparam int unsigned SKT_DZ_W = 17;
  localparam int unsigned SKT_NY_W = 54;
  localparam int unsigned SKT_DY_W = 33;

  typedef enum logic [SKT_CFG_IDX_W-1:0] {
    CFG_CENTER_U  = 3'd0,
    CFG_CENTER_V  = 3'd1,
    CFG_FOCAL_U   = 3'd2,
    CFG_FOCAL_V   = 3'd3,
    CFG_BASELINE  = 3'd4,
    CFG_DISP_MIN  = 3'd5,
    CFG_DISP_MAX  = 3'd6,
    CFG_ROW_LIMIT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [SKT_COORD_W-1:0] center_u;
    logic [SKT_COORD_W-1:0] center_v;
    logic [SKT_COORD_W-1:0] focal_u;
    logic [SKT_COORD_W-1:0] focal_v;
    logic [SKT_BASE_W-1:0]  baseline_um;
    logic [SKT_COORD_W-1:0] disp_floor;
    logic [SKT_COORD_W-1:0] disp_ceil;
    logic [SKT_COORD_W-1:0] row_limit;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic x_neg;
    logic y_neg;
  } meta_t;

  typedef struct packed {
    meta_t                  meta;
    logic [SKT_COORD_W-1:0] mag_x;
    logic [SKT_COORD_W-1:0] mag_y;
    logic [SKT_COORD_W-1:0] disp;
  } pair_t;

  typedef struct packed {
    logic                 valid;
    logic [SKT_OUT_W-1:0] x;
    logic [SKT_OUT_W-1:0] y;
    logic [SKT_OUT_W-1:0] z;
  } point_t;

  function automatic logic [SKT_OUT_W-1:0] sat32(input logic neg, input logic ovf,
                                                 input logic [SKT_QUOT_W-1:0] q);
    logic [SKT_OUT_W-1:0] r;
    if (neg) begin
      if (ovf || (q > 32'h8000_0000)) begin
        r = 32'h8000_0000;
      end else begin
        r = 32'(~q + 32'd1);
      end
    end else begin
      if (ovf || q[SKT_QUOT_W-1]) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = q;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stereo_keypoint_triangulator.sv @@
// Top level of the stereo keypoint triangulator: configuration registers,
// front classifier, middle queue, arithmetic back end and result queue.
// Depends on skt_pkg, skt_front, skt_fifo, skt_back and skt_div.
//
// Usage: a matched keypoint pair is written on the in_ ports with in_push
// and is taken on a clock edge where in_full is low. One result word per
// pair comes out in order on the out_ ports while out_empty is low and is
// taken on an edge where out_pop is high.
// A pair taken on the in_ ports passes the front register, the middle queue,
// three product and rounding stages and 32 divider stages (one quotient bit
// each); the word then enters the result queue. Throughput is one pair per
// cycle while the result queue has room; the 32-stage divider pipeline is
// fully overlapped. When the receiver stalls, the back end holds its
// pipeline once the result queue is full, the middle queue then fills and
// in_full rises. The cfg_ port writes one register per cycle; the user must
// use it only while no pair is in flight, as the block does not enforce
// this. Reset clears all queues and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module stereo_keypoint_triangulator
  import skt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = SKT_QUEUE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [SKT_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SKT_CFG_W-1:0]     cfg_data,
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic [SKT_COORD_W-1:0]   in_left_u,
  input  wire logic [SKT_COORD_W-1:0]   in_left_v,
  input  wire logic [SKT_COORD_W-1:0]   in_right_u,
  input  wire logic [SKT_COORD_W-1:0]   in_right_v,
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic                          out_point_valid,
  output logic signed [SKT_OUT_W-1:0]   out_point_x,
  output logic signed [SKT_OUT_W-1:0]   out_point_y,
  output logic signed [SKT_OUT_W-1:0]   out_point_z
);

  cfg_t   cfg_r, cfg_nxt;
  logic   mid_push, mid_pop, mid_full, mid_empty;
  pair_t  mid_wdata, mid_rdata;
  logic   res_push, res_full;
  point_t res_wdata, res_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_U:  cfg_nxt.center_u    = cfg_data[SKT_COORD_W-1:0];
        CFG_CENTER_V:  cfg_nxt.center_v    = cfg_data[SKT_COORD_W-1:0];
        CFG_FOCAL_U:   cfg_nxt.focal_u     = cfg_data[SKT_COORD_W-1:0];
        CFG_FOCAL_V:   cfg_nxt.focal_v     = cfg_data[SKT_COORD_W-1:0];
        CFG_BASELINE:  cfg_nxt.baseline_um = cfg_data[SKT_BASE_W-1:0];
        CFG_DISP_MIN:  cfg_nxt.disp_floor  = cfg_data[SKT_COORD_W-1:0];
        CFG_DISP_MAX:  cfg_nxt.disp_ceil   = cfg_data[SKT_COORD_W-1:0];
        CFG_ROW_LIMIT: cfg_nxt.row_limit   = cfg_data[SKT_COORD_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_u    <= 16'd0;
      cfg_r.center_v    <= 16'd0;
      cfg_r.focal_u     <= 16'd16;
      cfg_r.focal_v     <= 16'd16;
      cfg_r.baseline_um <= 20'd0;
      cfg_r.disp_floor  <= 16'd80;
      cfg_r.disp_ceil   <= 16'd1600;
      cfg_r.row_limit   <= 16'd80;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  skt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_left_u  (in_left_u),
    .in_left_v  (in_left_v),
    .in_right_u (in_right_u),
    .in_right_v (in_right_v),
    .mid_full   (mid_full),
    .mid_push   (mid_push),
    .mid_data   (mid_wdata)
  );

  skt_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(pair_t))) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty)
  );

  skt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_data  (res_wdata)
  );

  skt_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(point_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .pop   (out_pop),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (out_empty)
  );

  assign out_point_valid = res_rdata.valid;
  assign out_point_x     = res_rdata.x;
  assign out_point_y     = res_rdata.y;
  assign out_point_z     = res_rdata.z;

endmodule

`default_nettype wire

@@ hw/rtl/skt_fifo.sv @@
// Small register queue used between front and back and at the result side.
// Depends on nothing; depth must be a power of two of at least two.
`timescale 1ns / 1ps
`default_nettype none

module skt_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? AW'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = do_pop ? AW'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> !empty) else $error("queue empty after a push");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/skt_front.sv @@
// Front part: registers and classifies one keypoint pair per cycle while its
// output can move on. Depends on skt_pkg; feeds the queue in front of skt_back.
`timescale 1ns / 1ps
`default_nettype none

module skt_front
  import skt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [SKT_COORD_W-1:0] in_left_u,
  input  wire logic [SKT_COORD_W-1:0] in_left_v,
  input  wire logic [SKT_COORD_W-1:0] in_right_u,
  input  wire logic [SKT_COORD_W-1:0] in_right_v,
  input  wire logic                   mid_full,
  output logic                        mid_push,
  output pair_t                       mid_data
);

  logic                   f_valid_r, f_valid_nxt;
  pair_t                  f_data_r, f_data_nxt;
  logic [SKT_COORD_W-1:0] disp, off;
  logic                   take, move;

  assign in_full  = f_valid_r && mid_full;
  assign take     = in_push && !in_full;
  assign move     = f_valid_r && !mid_full;
  assign mid_push = move;
  assign mid_data = f_data_r;

  always_comb begin
    disp = SKT_COORD_W'(in_left_u - in_right_u);
    off  = (in_left_v >= in_right_v) ? SKT_COORD_W'(in_left_v - in_right_v)
                                     : SKT_COORD_W'(in_right_v - in_left_v);
    f_data_nxt.meta.valid = (in_left_u > in_right_u) && (disp > cfg.disp_floor) &&
                            (disp < cfg.disp_ceil) && (off < cfg.row_limit);
    f_data_nxt.meta.x_neg = in_left_u < cfg.center_u;
    f_data_nxt.meta.y_neg = in_left_v < cfg.center_v;
    f_data_nxt.mag_x = f_data_nxt.meta.x_neg ? SKT_COORD_W'(cfg.center_u - in_left_u)
                                             : SKT_COORD_W'(in_left_u - cfg.center_u);
    f_data_nxt.mag_y = f_data_nxt.meta.y_neg ? SKT_COORD_W'(cfg.center_v - in_left_v)
                                             : SKT_COORD_W'(in_left_v - cfg.center_v);
    f_data_nxt.disp  = disp;
    f_valid_nxt = take ? 1'b1 : (move ? 1'b0 : f_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_data_r <= f_data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/skt_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on nothing; used three times by skt_back.
`timescale 1ns / 1ps
`default_nettype none

module skt_div #(
  parameter int unsigned NW = 38,
  parameter int unsigned DW = 17,
  parameter int unsigned QW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quot,
  output logic               ovf
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [DW-1:0] den_r [QW];
  logic [DW-1:0] den_nxt [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] low_nxt [QW];
  logic [QW-1:0] q_r [QW];
  logic [QW-1:0] q_nxt [QW];
  logic          ovf_r [QW];
  logic          ovf_nxt [QW];

  always_comb begin
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] low_i;
    logic [QW-1:0] q_i;
    logic          ovf_i;
    logic [DW:0]   trial;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_i = DW'(num[NW-1:QW]);
        den_i = den;
        low_i = num[QW-1:0];
        q_i   = '0;
        ovf_i = CW'(num[NW-1:QW]) >= CW'(den);
      end else begin
        rem_i = rem_r[k-1];
        den_i = den_r[k-1];
        low_i = low_r[k-1];
        q_i   = q_r[k-1];
        ovf_i = ovf_r[k-1];
      end
      trial      = {rem_i, low_i[QW-1]};
      ge         = trial >= {1'b0, den_i};
      rem_nxt[k] = ge ? DW'(trial - {1'b0, den_i}) : DW'(trial);
      den_nxt[k] = den_i;
      low_nxt[k] = {low_i[QW-2:0], 1'b0};
      q_nxt[k]   = {q_i[QW-2:0], ge};
      ovf_nxt[k] = ovf_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_nxt[k];
        low_r[k] <= low_nxt[k];
        q_r[k]   <= q_nxt[k];
        ovf_r[k] <= ovf_nxt[k];
      end
    end
  end

  assign quot = q_r[QW-1];
  assign ovf  = ovf_r[QW-1];

endmodule

`default_nettype wire

@@ hw/rtl/skt_back.sv @@
// Back part: products, three pipelined dividers, rounding and saturation.
// Depends on skt_pkg and skt_div; pulls from the middle queue.
`timescale 1ns / 1ps
`default_nettype none

module skt_back
  import skt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  mid_empty,
  input  wire pair_t mid_data,
  output logic       mid_pop,
  input  wire logic  out_full,
  output logic       out_push,
  output point_t     out_data
);

  logic en;

  logic                        s1_v_r, s2_v_r, s3_v_r;
  meta_t                       s1_m_r, s2_m_r, s3_m_r;
  logic [35:0]                 s1_pz_r, s1_px_r, s2_pz_r, s2_px_r;
  logic [31:0]                 s1_pmy_r, s1_dv_r, s2_dv_r;
  logic [SKT_COORD_W-1:0]      s1_d_r, s2_d_r;
  logic [51:0]                 s2_py_r;
  logic [SKT_NZ_W-1:0]         s3_nz_r, s3_nx_r;
  logic [SKT_DZ_W-1:0]         s3_dz_r;
  logic [SKT_NY_W-1:0]         s3_ny_r;
  logic [SKT_DY_W-1:0]         s3_dy_r;
  logic [SKT_COORD_W-1:0]      fv;

  logic                        pv_r [SKT_QUOT_W];
  meta_t                       pm_r [SKT_QUOT_W];

  logic [SKT_QUOT_W-1:0]       qz, qx, qy;
  logic                        oz, ox, oy;

  assign en      = !out_full;
  assign mid_pop = en && !mid_empty;
  assign fv      = (cfg.focal_v == '0) ? SKT_COORD_W'(1) : cfg.focal_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      for (int k = 0; k < SKT_QUOT_W; k++) begin
        pv_r[k] <= 1'b0;
      end
    end else if (en) begin
      s1_v_r <= !mid_empty;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      pv_r[0] <= s3_v_r;
      for (int k = 1; k < SKT_QUOT_W; k++) begin
        pv_r[k] <= pv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m_r   <= mid_data.meta;
      s1_pz_r  <= 36'(cfg.focal_u * cfg.baseline_um);
      s1_px_r  <= 36'(mid_data.mag_x * cfg.baseline_um);
      s1_pmy_r <= 32'(mid_data.mag_y * cfg.focal_u);
      s1_dv_r  <= 32'(fv * mid_data.disp);
      s1_d_r   <= mid_data.disp;

      s2_m_r  <= s1_m_r;
      s2_pz_r <= s1_pz_r;
      s2_px_r <= s1_px_r;
      s2_py_r <= 52'(s1_pmy_r * cfg.baseline_um);
      s2_dv_r <= s1_dv_r;
      s2_d_r  <= s1_d_r;

      s3_m_r  <= s2_m_r;
      s3_nz_r <= SKT_NZ_W'({s2_pz_r, 1'b0}) + SKT_NZ_W'(s2_d_r);
      s3_nx_r <= SKT_NZ_W'({s2_px_r, 1'b0}) + SKT_NZ_W'(s2_d_r);
      s3_dz_r <= {s2_d_r, 1'b0};
      s3_ny_r <= SKT_NY_W'({s2_py_r, 1'b0}) + SKT_NY_W'(s2_dv_r);
      s3_dy_r <= {s2_dv_r, 1'b0};

      pm_r[0] <= s3_m_r;
      for (int k = 1; k < SKT_QUOT_W; k++) begin
        pm_r[k] <= pm_r[k-1];
      end
    end
  end

  skt_div #(.NW(SKT_NZ_W), .DW(SKT_DZ_W), .QW(SKT_QUOT_W)) u_div_z (
    .clk(clk), .en(en), .num(s3_nz_r), .den(s3_dz_r), .quot(qz), .ovf(oz)
  );

  skt_div #(.NW(SKT_NZ_W), .DW(SKT_DZ_W), .QW(SKT_QUOT_W)) u_div_x (
    .clk(clk), .en(en), .num(s3_nx_r), .den(s3_dz_r), .quot(qx), .ovf(ox)
  );

  skt_div #(.NW(SKT_NY_W), .DW(SKT_DY_W), .QW(SKT_QUOT_W)) u_div_y (
    .clk(clk), .en(en), .num(s3_ny_r), .den(s3_dy_r), .quot(qy), .ovf(oy)
  );

  always_comb begin
    out_push       = en && pv_r[SKT_QUOT_W-1];
    out_data.valid = pm_r[SKT_QUOT_W-1].valid;
    if (pm_r[SKT_QUOT_W-1].valid) begin
      out_data.x = sat32(pm_r[SKT_QUOT_W-1].x_neg, ox, qx);
      out_data.y = sat32(pm_r[SKT_QUOT_W-1].y_neg, oy, qy);
      out_data.z = sat32(1'b0, oz, qz);
    end else begin
      out_data.x = '0;
      out_data.y = '0;
      out_data.z = '0;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && !out_data.valid) |-> (out_data.x == '0 && out_data.y == '0 &&
    out_data.z == '0)) else $error("invalid word carries coordinates");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full) else $error("result pushed into a full queue");
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |=> s1_v_r) else $error("popped word did not enter the pipeline");
`endif

endmodule

`default_nettype wire

@@ bench/stereo_keypoint_triangulator_test.sv @@
// Self-checking bench for stereo_keypoint_triangulator: directed pairs, then
// random register settings and random pairs, predicted and compared in order.
// Depends on skt_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none

module stereo_keypoint_triangulator_test;
  import skt_pkg::*;

  typedef struct {
    logic              valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_word_t;

  typedef struct {
    int unsigned      phase;
    logic [15:0]      lu, lv, ru, rv;
    bit               typed;
    point_word_t      known;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [SKT_CFG_IDX_W-1:0] cfg_index = '0;
  logic [SKT_CFG_W-1:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [15:0] in_left_u = '0, in_left_v = '0, in_right_u = '0, in_right_v = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_point_valid;
  logic signed [31:0] out_point_x, out_point_y, out_point_z;

  stereo_keypoint_triangulator u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full),
    .in_left_u(in_left_u), .in_left_v(in_left_v),
    .in_right_u(in_right_u), .in_right_v(in_right_v),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_point_valid(out_point_valid),
    .out_point_x(out_point_x), .out_point_y(out_point_y), .out_point_z(out_point_z)
  );

  always #5 clk = ~clk;

  logic [15:0] center_u, center_v, focal_u, focal_v;
  logic [19:0] baseline_um;
  logic [15:0] disp_floor, disp_ceil, row_limit;

  point_word_t pending_points[$];
  int unsigned mismatches = 0;
  int unsigned pairs_sent = 0;
  int unsigned points_seen = 0;
  int unsigned valid_words = 0;
  int unsigned settings_used = 0;
  bit quiet = 1'b0;

  function automatic logic [63:0] div_nearest(logic [63:0] num, logic [63:0] den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [31:0] sign_clamp(bit neg, logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(-mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic point_word_t triangulate(logic [15:0] lu, logic [15:0] lv,
                                               logic [15:0] ru, logic [15:0] rv);
    point_word_t p;
    longint disp, off, dx, dy;
    logic [63:0] d, fv, mx, my, qx, qy, qz;
    disp = longint'(lu) - longint'(ru);
    off = longint'(lv) - longint'(rv);
    if (off < 0) off = -off;
    p = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
    if (!(disp > longint'(disp_floor) && disp < longint'(disp_ceil) &&
          off < longint'(row_limit))) return p;
    d = 64'(disp);
    fv = (focal_v == 0) ? 64'd1 : 64'(focal_v);
    dx = longint'(lu) - longint'(center_u);
    dy = longint'(lv) - longint'(center_v);
    mx = 64'(dx < 0 ? -dx : dx);
    my = 64'(dy < 0 ? -dy : dy);
    qz = div_nearest(64'(focal_u) * 64'(baseline_um), d);
    qx = div_nearest(mx * 64'(baseline_um), d);
    qy = div_nearest(my * 64'(focal_u) * 64'(baseline_um), fv * d);
    p.valid = 1'b1;
    p.x = sign_clamp(dx < 0 && qx != 0, qx);
    p.y = sign_clamp(dy < 0 && qy != 0, qy);
    p.z = sign_clamp(1'b0, qz);
    return p;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [19:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      CFG_CENTER_U:  center_u = value[15:0];
      CFG_CENTER_V:  center_v = value[15:0];
      CFG_FOCAL_U:   focal_u = value[15:0];
      CFG_FOCAL_V:   focal_v = value[15:0];
      CFG_BASELINE:  baseline_um = value;
      CFG_DISP_MIN:  disp_floor = value[15:0];
      CFG_DISP_MAX:  disp_ceil = value[15:0];
      CFG_ROW_LIMIT: row_limit = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic drain_points();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_pair(logic [15:0] lu, logic [15:0] lv, logic [15:0] ru,
                           logic [15:0] rv, bit typed, point_word_t known);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(16);
    @(negedge clk);
    if (gap != 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_left_u = lu;
    in_left_v = lv;
    in_right_u = ru;
    in_right_v = rv;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    pending_points.insert(pending_points.size(),
                          typed ? known : triangulate(lu, lv, ru, rv));
    pairs_sent++;
  endtask

  task automatic finish_burst();
    @(negedge clk);
    in_push = 1'b0;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic pick_setting();
    logic [15:0] lo, hi;
    write_reg(CFG_CENTER_U, {4'($urandom), pick16()});
    write_reg(CFG_CENTER_V, {4'($urandom), pick16()});
    write_reg(CFG_FOCAL_U, {4'($urandom), ($urandom_range(5) == 0) ? pick16()
                                          : 16'($urandom_range(1, 16000))});
    write_reg(CFG_FOCAL_V, {4'($urandom), ($urandom_range(5) == 0) ? pick16()
                                          : 16'($urandom_range(1, 16000))});
    case ($urandom_range(4))
      0: write_reg(CFG_BASELINE, 20'h0);
      1: write_reg(CFG_BASELINE, 20'hFFFFF);
      default: write_reg(CFG_BASELINE, 20'($urandom));
    endcase
    if ($urandom_range(4) == 0) begin
      lo = pick16();
      hi = pick16();
    end else begin
      lo = 16'($urandom_range(0, 2000));
      hi = lo + 16'($urandom_range(2, 20000));
    end
    write_reg(CFG_DISP_MIN, {4'($urandom), lo});
    write_reg(CFG_DISP_MAX, {4'($urandom), hi});
    write_reg(CFG_ROW_LIMIT, {4'($urandom), ($urandom_range(4) == 0) ? pick16()
                                            : 16'($urandom_range(1, 400))});
    settings_used++;
  endtask

  task automatic send_random_pair();
    logic [15:0] lu, lv, ru, rv;
    int unsigned d, off;
    point_word_t none;
    none = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
    if ($urandom_range(9) < 7 && 32'(disp_ceil) > 32'(disp_floor) + 1) begin
      d = $urandom_range(32'(disp_floor) + 1, 32'(disp_ceil) - 1);
      off = (row_limit == 0) ? 0 : $urandom_range(32'(row_limit) - 1);
      ru = 16'($urandom_range(65535 - d));
      lu = ru + 16'(d);
      lv = 16'($urandom);
      rv = ($urandom_range(1) && 32'(lv) >= off) || 32'(lv) + off > 65535 ?
           lv - 16'(off) : lv + 16'(off);
    end else begin
      lu = pick16();
      lv = pick16();
      ru = pick16();
      rv = 16'($urandom);
    end
    send_pair(lu, lv, ru, rv, 1'b0, none);
  endtask

  initial begin
    int unsigned n;
    wait (rst_n === 1'b1);
    forever begin
      n = quiet ? 0 : $urandom_range(16);
      if (n != 0) begin
        out_pop = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_pop = 1'b1;
      do @(posedge clk); while (out_empty);
      points_seen++;
      if (out_point_valid) valid_words++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word x=%0d y=%0d z=%0d",
                                       out_point_x, out_point_y, out_point_z);
      end else begin
        point_word_t e;
        e = pending_points.pop_front();
        if (e.valid !== out_point_valid || e.x !== out_point_x ||
            e.y !== out_point_y || e.z !== out_point_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected v=%0b x=%0d y=%0d z=%0d, got v=%0b x=%0d y=%0d z=%0d",
                     e.valid, e.x, e.y, e.z, out_point_valid, out_point_x,
                     out_point_y, out_point_z);
        end
      end
      @(negedge clk);
    end
  end

  pair_row_t rows[$];

  initial begin
    point_word_t zero_word, valid_zero;
    int unsigned cur_phase;
    zero_word = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
    valid_zero = '{1'b1, 32'sd0, 32'sd0, 32'sd0};
    center_u = 0; center_v = 0; focal_u = 16; focal_v = 16; baseline_um = 0;
    disp_floor = 80; disp_ceil = 1600; row_limit = 80;

    // With the reset settings the baseline is zero, so valid pairs give a zero point.
    rows = '{
      '{0, 16'd0, 16'd0, 16'd0, 16'd0, 1, zero_word},
      '{0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1, zero_word},
      '{0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, zero_word},
      '{0, 16'd81, 16'd0, 16'd0, 16'd0, 1, valid_zero},
      '{0, 16'd80, 16'd0, 16'd0, 16'd0, 1, zero_word},
      '{0, 16'd1599, 16'd0, 16'd0, 16'd0, 1, valid_zero},
      '{0, 16'd1600, 16'd0, 16'd0, 16'd0, 1, zero_word},
      '{0, 16'd100, 16'd79, 16'd0, 16'd0, 1, valid_zero},
      '{0, 16'd100, 16'd80, 16'd0, 16'd0, 1, zero_word},
      '{0, 16'd100, 16'd0, 16'd0, 16'd79, 1, valid_zero},
      '{0, 16'd100, 16'd0, 16'd0, 16'd80, 1, zero_word},
      '{0, 16'd0, 16'd0, 16'd200, 16'd0, 1, zero_word},
      '{1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 0, zero_word},
      '{1, 16'd1, 16'd0, 16'd0, 16'd0, 0, zero_word},
      '{1, 16'd100, 16'd0, 16'd99, 16'd0, 0, zero_word},
      '{1, 16'h8000, 16'h8000, 16'h7FF0, 16'h8000, 0, zero_word},
      '{1, 16'h9000, 16'hFFFF, 16'h8000, 16'hFFF0, 0, zero_word},
      '{2, 16'd500, 16'd300, 16'd100, 16'd300, 0, zero_word},
      '{2, 16'd700, 16'd10, 16'd50, 16'd12, 0, zero_word},
      '{3, 16'hFFFF, 16'h1234, 16'hFFF0, 16'h1234, 0, zero_word}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cur_phase = 0;
    foreach (rows[i]) begin
      if (rows[i].phase != cur_phase) begin
        finish_burst();
        drain_points();
        cur_phase = rows[i].phase;
        case (cur_phase)
          1: begin
            write_reg(CFG_CENTER_U, 20'h08000);
            write_reg(CFG_CENTER_V, 20'hF8000);
            write_reg(CFG_FOCAL_U, 20'h0FFFF);
            write_reg(CFG_FOCAL_V, 20'h00001);
            write_reg(CFG_BASELINE, 20'hFFFFF);
            write_reg(CFG_DISP_MIN, 20'h00000);
            write_reg(CFG_DISP_MAX, 20'hFFFFF);
            write_reg(CFG_ROW_LIMIT, 20'h0FFFF);
          end
          2: begin
            write_reg(CFG_FOCAL_U, 20'h0);
            write_reg(CFG_FOCAL_V, 20'h0);
            write_reg(CFG_BASELINE, 20'd120000);
            write_reg(CFG_DISP_MAX, 20'd1000);
          end
          default: begin
            write_reg(CFG_DISP_MIN, 20'd200);
            write_reg(CFG_DISP_MAX, 20'd201);
          end
        endcase
        settings_used++;
      end
      send_pair(rows[i].lu, rows[i].lv, rows[i].ru, rows[i].rv,
                rows[i].typed, rows[i].known);
    end
    finish_burst();
    drain_points();

    for (int s = 0; s < 8; s++) begin
      pick_setting();
      quiet = (s % 3 == 2);
      for (int k = 0; k < 250; k++) send_random_pair();
      finish_burst();
      drain_points();
    end
    quiet = 1'b0;

    $display("Sent %0d keypoint pairs over %0d register settings.", pairs_sent,
             settings_used);
    $display("Checked %0d result words, %0d of them valid points.", points_seen,
             valid_words);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("Mismatches: %0d.", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timed out with %0d result words outstanding.", pending_points.size());
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
